### hdl/rlb_pkg.sv
// Shared types, blend mode codes and the divide-by-255 helper for the layer blend unit.
`timescale 1ns / 1ps
`default_nettype none

package rlb_pkg;

  localparam int unsigned NUM_LANES = 3;

  typedef enum logic [4:0] {
    MODE_NORMAL        = 5'd0,
    MODE_LIGHTEN       = 5'd1,
    MODE_DARKEN        = 5'd2,
    MODE_MULTIPLY      = 5'd3,
    MODE_AVERAGE       = 5'd4,
    MODE_ADD           = 5'd5,
    MODE_SUBTRACT      = 5'd6,
    MODE_DIFFERENCE    = 5'd7,
    MODE_NEGATION      = 5'd8,
    MODE_SCREEN        = 5'd9,
    MODE_EXCLUSION     = 5'd10,
    MODE_OVERLAY       = 5'd11,
    MODE_SOFT_LIGHT    = 5'd12,
    MODE_HARD_LIGHT    = 5'd13,
    MODE_COLOR_DODGE   = 5'd14,
    MODE_COLOR_BURN    = 5'd15,
    MODE_LINEAR_DODGE  = 5'd16,
    MODE_LINEAR_BURN   = 5'd17,
    MODE_LINEAR_LIGHT  = 5'd18,
    MODE_VIVID_LIGHT   = 5'd19,
    MODE_PIN_LIGHT     = 5'd20,
    MODE_HARD_MIX      = 5'd21,
    MODE_REFLECT       = 5'd22,
    MODE_GLOW          = 5'd23,
    MODE_PHOENIX       = 5'd24
  } mode_e;

  typedef struct packed {
    logic [4:0] func;
    logic       use_alpha;
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic [7:0] top_alpha;
    logic [7:0] bottom_red;
    logic [7:0] bottom_green;
    logic [7:0] bottom_blue;
    logic [7:0] bottom_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic       use_alpha;
    logic [7:0] ta;
    logic [7:0] ba;
  } side_t;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
    logic [7:0] divisor;
    logic       ovf;
    logic       pole;
    logic       burn;
    logic       use_div;
    logic       hmix;
    logic [7:0] f_simple;
    logic [7:0] b;
  } div_t;

  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [17:0] q0;
    logic [17:0] r;
    logic [8:0]  q;
    q0 = ({1'b0, x} + {9'd0, x[16:8]}) >> 8;
    r  = {1'b0, x} - ({q0[9:0], 8'd0} - q0);
    q  = q0[8:0];
    if (r >= 18'd510) begin
      q = q + 9'd2;
    end else if (r >= 18'd255) begin
      q = q + 9'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

### hdl/rlb_div_stage.sv
// One registered stage of the lane divider, retiring two quotient bits.
`timescale 1ns / 1ps
`default_nettype none

module rlb_div_stage (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire rlb_pkg::div_t d,
  output rlb_pkg::div_t     q
);

  rlb_pkg::div_t nxt;
  logic [8:0]    r9a;
  logic [8:0]    r9b;
  logic [7:0]    rem_a;
  logic          bit_a;
  logic          bit_b;

  always_comb begin
    nxt   = d;
    r9a   = {d.rem, d.low[7]};
    bit_a = (r9a >= {1'b0, d.divisor});
    rem_a = bit_a ? 8'(r9a - {1'b0, d.divisor}) : r9a[7:0];
    r9b   = {rem_a, d.low[6]};
    bit_b = (r9b >= {1'b0, d.divisor});
    nxt.rem = bit_b ? 8'(r9b - {1'b0, d.divisor}) : r9b[7:0];
    nxt.low = {d.low[5:0], 2'b00};
    nxt.quo = {d.quo[5:0], bit_a, bit_b};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/rlb_lane.sv
// One color channel lane: blend mode evaluation with a pipelined divider.
`timescale 1ns / 1ps
`default_nettype none

module rlb_lane (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [4:0] mode,
  input  wire logic [7:0] t,
  input  wire logic [7:0] b,
  output logic [7:0]      f,
  output logic [7:0]      b_out
);

  rlb_pkg::mode_e md;
  logic [7:0]  k;
  logic [7:0]  b2;
  logic [7:0]  sq_src;
  logic [15:0] sq;
  logic [15:0] dvd_c;
  logic [7:0]  dsr_c;
  logic        pole_c;
  logic        burn_c;
  logic        usediv_c;

  rlb_pkg::mode_e m1;
  logic [7:0]  t1;
  logic [7:0]  b1;
  logic [15:0] p_tb;
  logic [15:0] p_inv;
  logic [15:0] p_kb;
  logic [15:0] p_kinv;
  logic [15:0] dvd1;
  logic [7:0]  dsr1;
  logic        pole1;
  logic        burn1;
  logic        usediv1;
  logic        hmix1;

  logic [8:0]  s;
  logic [8:0]  s2;
  logic [7:0]  b12;
  logic [16:0] x;
  logic [8:0]  q;
  logic [7:0]  fs;
  logic [7:0]  tmax;
  logic [7:0]  tmin;
  logic [7:0]  adiff;
  rlb_pkg::div_t init_c;

  rlb_pkg::div_t dv [0:4];
  logic [7:0]  r;
  logic [7:0]  f_next;

  always_comb begin
    md     = rlb_pkg::mode_e'(mode);
    k      = {1'b0, t[7:1]} + 8'd64;
    b2     = {b[6:0], 1'b0};
    sq_src = (md == rlb_pkg::MODE_GLOW) ? b : t;
    sq     = sq_src * sq_src;
    dvd_c    = 16'd0;
    dsr_c    = 8'd0;
    pole_c   = 1'b0;
    burn_c   = 1'b0;
    usediv_c = 1'b1;
    case (md)
      rlb_pkg::MODE_COLOR_DODGE: begin
        dvd_c  = {t, 8'd0};
        dsr_c  = ~b;
        pole_c = (b == 8'hFF);
      end
      rlb_pkg::MODE_COLOR_BURN: begin
        dvd_c  = {~t, 8'd0};
        dsr_c  = b;
        pole_c = (b == 8'd0);
        burn_c = 1'b1;
      end
      rlb_pkg::MODE_VIVID_LIGHT, rlb_pkg::MODE_HARD_MIX: begin
        if (b[7]) begin
          dvd_c  = {t, 8'd0};
          dsr_c  = ~b2;
          pole_c = (b2 == 8'hFF);
        end else begin
          dvd_c  = {~t, 8'd0};
          dsr_c  = b2;
          pole_c = (b2 == 8'd0);
          burn_c = 1'b1;
        end
      end
      rlb_pkg::MODE_REFLECT: begin
        dvd_c  = sq;
        dsr_c  = ~b;
        pole_c = (b == 8'hFF);
      end
      rlb_pkg::MODE_GLOW: begin
        dvd_c  = sq;
        dsr_c  = ~t;
        pole_c = (t == 8'hFF);
      end
      default: begin
        usediv_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1      <= md;
      t1      <= t;
      b1      <= b;
      p_tb    <= t * b;
      p_inv   <= (8'd255 - t) * (8'd255 - b);
      p_kb    <= k * b;
      p_kinv  <= (8'd255 - k) * (8'd255 - b);
      dvd1    <= dvd_c;
      dsr1    <= dsr_c;
      pole1   <= pole_c;
      burn1   <= burn_c;
      usediv1 <= usediv_c;
      hmix1   <= (md == rlb_pkg::MODE_HARD_MIX);
    end
  end

  always_comb begin
    s     = {1'b0, t1} + {1'b0, b1};
    b12   = {b1[6:0], 1'b0};
    s2    = {1'b0, t1} + {1'b0, b12};
    tmax  = (t1 > b1) ? t1 : b1;
    tmin  = (t1 > b1) ? b1 : t1;
    adiff = tmax - tmin;
    case (m1)
      rlb_pkg::MODE_MULTIPLY:   x = {1'b0, p_tb};
      rlb_pkg::MODE_EXCLUSION:  x = {p_tb, 1'b0};
      rlb_pkg::MODE_OVERLAY:    x = b1[7] ? {p_inv, 1'b0} : {p_tb, 1'b0};
      rlb_pkg::MODE_HARD_LIGHT: x = t1[7] ? {p_inv, 1'b0} : {p_tb, 1'b0};
      rlb_pkg::MODE_SOFT_LIGHT: x = b1[7] ? ({p_kinv, 1'b0} + 17'd254) : {p_kb, 1'b0};
      default:                  x = 17'd0;
    endcase
    q = rlb_pkg::div255(x);
    case (m1)
      rlb_pkg::MODE_LIGHTEN:    fs = tmax;
      rlb_pkg::MODE_DARKEN:     fs = tmin;
      rlb_pkg::MODE_MULTIPLY:   fs = q[7:0];
      rlb_pkg::MODE_AVERAGE:    fs = s[8:1];
      rlb_pkg::MODE_ADD, rlb_pkg::MODE_LINEAR_DODGE: begin
        fs = (s > 9'd255) ? 8'hFF : s[7:0];
      end
      rlb_pkg::MODE_SUBTRACT, rlb_pkg::MODE_LINEAR_BURN: begin
        fs = (s < 9'd255) ? 8'd0 : 8'(s - 9'd255);
      end
      rlb_pkg::MODE_DIFFERENCE: fs = adiff;
      rlb_pkg::MODE_NEGATION:   fs = (s >= 9'd255) ? 8'(9'd510 - s) : s[7:0];
      rlb_pkg::MODE_SCREEN:     fs = ~p_inv[15:8];
      rlb_pkg::MODE_EXCLUSION:  fs = 8'(s - q);
      rlb_pkg::MODE_OVERLAY, rlb_pkg::MODE_SOFT_LIGHT: begin
        fs = b1[7] ? ~q[7:0] : q[7:0];
      end
      rlb_pkg::MODE_HARD_LIGHT: fs = t1[7] ? ~q[7:0] : q[7:0];
      rlb_pkg::MODE_LINEAR_LIGHT: begin
        if (b1[7]) begin
          fs = (s2 > 9'd255) ? 8'hFF : s2[7:0];
        end else begin
          fs = (s2 < 9'd255) ? 8'd0 : 8'(s2 - 9'd255);
        end
      end
      rlb_pkg::MODE_PIN_LIGHT: begin
        if (b1[7]) begin
          fs = (t1 > b12) ? t1 : b12;
        end else begin
          fs = (t1 < b12) ? t1 : b12;
        end
      end
      rlb_pkg::MODE_PHOENIX:    fs = ~adiff;
      default:                  fs = t1;
    endcase
    init_c.rem      = dvd1[15:8];
    init_c.low      = dvd1[7:0];
    init_c.quo      = 8'd0;
    init_c.divisor  = dsr1;
    init_c.ovf      = (dvd1[15:8] >= dsr1);
    init_c.pole     = pole1;
    init_c.burn     = burn1;
    init_c.use_div  = usediv1;
    init_c.hmix     = hmix1;
    init_c.f_simple = fs;
    init_c.b        = b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= init_c;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    rlb_div_stage u_stage (
      .clk (clk),
      .en  (en),
      .d   (dv[i]),
      .q   (dv[i+1])
    );
  end

  always_comb begin
    if (dv[4].burn) begin
      r = (dv[4].pole || dv[4].ovf || dv[4].quo == 8'hFF) ? 8'd0 : ~dv[4].quo;
    end else begin
      r = (dv[4].pole || dv[4].ovf) ? 8'hFF : dv[4].quo;
    end
    if (!dv[4].use_div) begin
      f_next = dv[4].f_simple;
    end else if (dv[4].hmix) begin
      f_next = r[7] ? 8'hFF : 8'd0;
    end else begin
      f_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f     <= f_next;
      b_out <= dv[4].b;
    end
  end

endmodule

`default_nettype wire

### hdl/rlb_merge.sv
// Merge stage: alpha weighting of the three lane results and output alpha.
`timescale 1ns / 1ps
`default_nettype none

module rlb_merge (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire rlb_pkg::side_t                       sd,
  input  wire logic [rlb_pkg::NUM_LANES-1:0][7:0]   f,
  input  wire logic [rlb_pkg::NUM_LANES-1:0][7:0]   fb,
  output rlb_pkg::pix_out_t                         out_data
);

  logic                                  ua;
  logic [rlb_pkg::NUM_LANES-1:0][7:0]    f8;
  logic [rlb_pkg::NUM_LANES-1:0][15:0]   sum;
  logic [15:0]                           asum;
  logic [rlb_pkg::NUM_LANES-1:0][15:0]   sum_c;
  logic [15:0]                           p_a;
  logic [15:0]                           p_b;
  logic [rlb_pkg::NUM_LANES-1:0][8:0]    cq;
  logic [rlb_pkg::NUM_LANES-1:0][7:0]    ch;
  logic [8:0]                            aq;
  logic [7:0]                            alpha;

  always_comb begin
    for (int c = 0; c < rlb_pkg::NUM_LANES; c++) begin
      sum_c[c] = 16'(sd.ta * f[c]) + 16'((8'd255 - sd.ta) * fb[c]);
    end
    p_a = sd.ta * sd.ta;
    p_b = (8'd255 - sd.ta) * sd.ba;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua   <= sd.use_alpha;
      f8   <= f;
      sum  <= sum_c;
      asum <= p_a + p_b;
    end
  end

  always_comb begin
    for (int c = 0; c < rlb_pkg::NUM_LANES; c++) begin
      cq[c] = rlb_pkg::div255({1'b0, sum[c]});
      ch[c] = ua ? cq[c][7:0] : f8[c];
    end
    aq    = rlb_pkg::div255({1'b0, asum});
    alpha = ua ? aq[7:0] : 8'hFF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_red   <= ch[0];
      out_data.out_green <= ch[1];
      out_data.out_blue  <= ch[2];
      out_data.out_alpha <= alpha;
    end
  end

endmodule

`default_nettype wire

### hdl/rgba_layer_blend_modes.sv
// Top level of the RGBA layer blend unit: input register, three lanes, merge stage.
//
//   channel | valid     | ready     | payload
//   input   | src_valid | src_ready | src_data (rlb_pkg::pix_in_t)
//   output  | dst_valid | dst_ready | dst_data (rlb_pkg::pix_out_t)
//
// One pixel per clock is accepted unless a result waits on dst_ready. A pixel passes
// the input register, each lane's product register, divider input register, the four
// two-bit divider stages and result register, and the merge sum and output registers.
// The whole pipeline moves together and holds while a result waits on dst_ready.
// Reset clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rgba_layer_blend_modes (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              src_valid,
  output logic                   src_ready,
  input  wire rlb_pkg::pix_in_t  src_data,
  output logic                   dst_valid,
  input  wire logic              dst_ready,
  output rlb_pkg::pix_out_t      dst_data
);

  logic                                 adv;
  logic [9:0]                           vld;
  rlb_pkg::pix_in_t                     in_q;
  rlb_pkg::side_t                       sd [1:7];
  logic [rlb_pkg::NUM_LANES-1:0][7:0]   tch;
  logic [rlb_pkg::NUM_LANES-1:0][7:0]   bch;
  logic [rlb_pkg::NUM_LANES-1:0][7:0]   f;
  logic [rlb_pkg::NUM_LANES-1:0][7:0]   fb;

  assign adv       = !vld[9] || dst_ready;
  assign src_ready = adv;
  assign dst_valid = vld[9];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[8:0], src_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_q            <= src_data;
      sd[1].use_alpha <= in_q.use_alpha;
      sd[1].ta        <= in_q.top_alpha;
      sd[1].ba        <= in_q.bottom_alpha;
      for (int i = 2; i < 8; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  always_comb begin
    tch[0] = in_q.top_red;
    tch[1] = in_q.top_green;
    tch[2] = in_q.top_blue;
    bch[0] = in_q.bottom_red;
    bch[1] = in_q.bottom_green;
    bch[2] = in_q.bottom_blue;
  end

  for (genvar c = 0; c < rlb_pkg::NUM_LANES; c++) begin : g_lane
    rlb_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .mode  (in_q.func),
      .t     (tch[c]),
      .b     (bch[c]),
      .f     (f[c]),
      .b_out (fb[c])
    );
  end

  rlb_merge u_merge (
    .clk      (clk),
    .en       (adv),
    .sd       (sd[7]),
    .f        (f),
    .fb       (fb),
    .out_data (dst_data)
  );

endmodule

`default_nettype wire

### hdl/rlb_checker.sv
// Port-level checker for the layer blend unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rlb_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              src_valid,
  input wire logic              src_ready,
  input wire rlb_pkg::pix_in_t  src_data,
  input wire logic              dst_valid,
  input wire logic              dst_ready,
  input wire rlb_pkg::pix_out_t dst_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("Result shown right after reset.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !dst_valid |-> src_ready)
    else $error("Input refused with no result pending.");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && !dst_ready) |-> !src_ready)
    else $error("Input taken while the pipeline is stalled.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && !dst_ready) |=> (dst_valid && $stable(dst_data)))
    else $error("Stalled result changed.");

endmodule

bind rgba_layer_blend_modes rlb_checker u_rlb_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_ready (src_ready),
  .src_data  (src_data),
  .dst_valid (dst_valid),
  .dst_ready (dst_ready),
  .dst_data  (dst_data)
);

`default_nettype wire
